### hw/rtl/bcd_pkg.sv
// ----------------------------------------------------------------------------
// bcd_pkg: shared types and constants of the block change detector
// widths of the pixel, sum and score fields, register indexes, reset values,
// divider state and the control/status structs between top and divider
// ----------------------------------------------------------------------------
`default_nettype none

package bcd_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned NUM_CHAN   = 3;
  localparam int unsigned TERM_SUM_W = 10;  // three 8 bit terms
  localparam int unsigned SUM_W      = 20;
  localparam int unsigned QUOT_W     = SUM_W - 2;  // sum after the divide by four
  localparam int unsigned SCORE_W    = 10;
  localparam int unsigned HALF_W     = 5;
  localparam int unsigned CTHR_W     = 8;
  localparam int unsigned ATHR_W     = 10;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 32;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HALF_SIDE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CHAN_THR  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACT_THR   = 2'd2;

  // register reset values
  localparam logic [HALF_W-1:0] HALF_RST = 5'd5;
  localparam logic [CTHR_W-1:0] CTHR_RST = 8'd40;
  localparam logic [ATHR_W-1:0] ATHR_RST = 10'd30;

  localparam logic [SUM_W-1:0]   SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_e;

  typedef struct packed {
    logic start;  // last item accepted, latch sum and begin
    logic take;   // result moved to the output register
  } div_ctrl_t;

  typedef struct packed {
    logic idle;
    logic done;
  } div_stat_t;

endpackage

`default_nettype wire

### hw/rtl/bcd_lane.sv
// ----------------------------------------------------------------------------
// bcd_lane: one color channel lane
// absolute difference of the two frames, kept only when above the threshold
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_lane (
  input  wire logic [bcd_pkg::PIX_W-1:0]  first_i,
  input  wire logic [bcd_pkg::PIX_W-1:0]  second_i,
  input  wire logic [bcd_pkg::CTHR_W-1:0] thr_i,
  output logic      [bcd_pkg::PIX_W-1:0]  term_o
);

  logic [bcd_pkg::PIX_W-1:0] diff;

  always_comb begin
    if (first_i > second_i) begin
      diff = first_i - second_i;
    end else begin
      diff = second_i - first_i;
    end
    term_o = (diff > thr_i) ? diff : '0;
  end

endmodule

`default_nettype wire

### hw/rtl/bcd_merge.sv
// ----------------------------------------------------------------------------
// bcd_merge: merging stage of the channel lanes
// adds the lane terms to the running block sum, saturating, clears on last
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_merge (
  input  wire logic                                            clk_i,
  input  wire logic                                            rst_ni,
  input  wire logic [bcd_pkg::NUM_CHAN-1:0][bcd_pkg::PIX_W-1:0] term_i,
  input  wire logic                                            accept_i,
  input  wire logic                                            last_i,
  output logic      [bcd_pkg::SUM_W-1:0]                       sum_o
);

  logic [bcd_pkg::SUM_W-1:0]      acc_q, acc_d;
  logic [bcd_pkg::TERM_SUM_W-1:0] add;
  logic [bcd_pkg::SUM_W:0]        total;

  always_comb begin
    add   = bcd_pkg::TERM_SUM_W'(term_i[0]) + bcd_pkg::TERM_SUM_W'(term_i[1])
          + bcd_pkg::TERM_SUM_W'(term_i[2]);
    total = {1'b0, acc_q} + (bcd_pkg::SUM_W + 1)'(add);
    // saturate instead of wrapping on overlong blocks
    sum_o = total[bcd_pkg::SUM_W] ? bcd_pkg::SUM_MAX : total[bcd_pkg::SUM_W-1:0];
    acc_d = acc_q;
    if (accept_i) begin
      acc_d = last_i ? '0 : sum_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_d;
    end
  end

endmodule

`default_nettype wire

### hw/rtl/bcd_div.sv
// ----------------------------------------------------------------------------
// bcd_div: block score divider
// restoring divide of (sum / 4) by half^2, one quotient bit per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_div #(
  parameter int unsigned MAX_HALF_SIDE = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire bcd_pkg::div_ctrl_t            ctrl_i,
  input  wire logic [bcd_pkg::SUM_W-1:0]     sum_i,
  input  wire logic [bcd_pkg::HALF_W-1:0]    half_i,
  output bcd_pkg::div_stat_t                 stat_o,
  output logic      [bcd_pkg::SUM_W-1:0]     sum_o,
  output logic      [bcd_pkg::QUOT_W-1:0]    quot_o
);

  localparam int unsigned HW    = $clog2(MAX_HALF_SIDE + 1);
  localparam int unsigned DW    = 2 * HW;
  localparam int unsigned CMP_W = (HW > bcd_pkg::HALF_W) ? HW : bcd_pkg::HALF_W;
  localparam int unsigned CNT_W = $clog2(bcd_pkg::QUOT_W + 1);

  bcd_pkg::div_state_e state_q, state_d;

  logic [CNT_W-1:0]            cnt_q, cnt_d;
  logic [bcd_pkg::QUOT_W-1:0]  quo_q, quo_d;
  logic [DW-1:0]               rem_q, rem_d;
  logic [DW-1:0]               dvs_q, dvs_d;
  logic [bcd_pkg::SUM_W-1:0]   sum_q, sum_d;

  logic [CMP_W-1:0] half_ext;
  logic [HW-1:0]    half_eff;
  logic [DW-1:0]    half_wide;
  logic [DW:0]      rem_sh;
  logic [DW:0]      rem_sub;
  logic             fits;

  // out of range half sides are clamped to 1 .. MAX_HALF_SIDE
  always_comb begin
    half_ext = CMP_W'(half_i);
    if (half_ext == '0) begin
      half_eff = HW'(1);
    end else if (half_ext > CMP_W'(MAX_HALF_SIDE)) begin
      half_eff = HW'(MAX_HALF_SIDE);
    end else begin
      half_eff = half_ext[HW-1:0];
    end
    half_wide = DW'(half_eff);
  end

  always_comb begin
    rem_sh  = {rem_q, quo_q[bcd_pkg::QUOT_W-1]};
    rem_sub = rem_sh - {1'b0, dvs_q};
    fits    = rem_sh >= {1'b0, dvs_q};
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bcd_pkg::DIV_IDLE: begin
        if (ctrl_i.start) begin
          state_d = bcd_pkg::DIV_RUN;
        end
      end
      bcd_pkg::DIV_RUN: begin
        if (cnt_q == CNT_W'(1)) begin
          state_d = bcd_pkg::DIV_DONE;
        end
      end
      bcd_pkg::DIV_DONE: begin
        if (ctrl_i.take) begin
          state_d = bcd_pkg::DIV_IDLE;
        end
      end
      default: state_d = bcd_pkg::DIV_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    sum_d  = sum_q;
    stat_o = '{idle: 1'b0, done: 1'b0};
    case (state_q)
      bcd_pkg::DIV_IDLE: begin
        stat_o.idle = 1'b1;
        if (ctrl_i.start) begin
          cnt_d = CNT_W'(bcd_pkg::QUOT_W);
          quo_d = sum_i[bcd_pkg::SUM_W-1:2];  // divide by four is a shift
          rem_d = '0;
          dvs_d = half_wide * half_wide;
          sum_d = sum_i;
        end
      end
      bcd_pkg::DIV_RUN: begin
        cnt_d = cnt_q - CNT_W'(1);
        quo_d = {quo_q[bcd_pkg::QUOT_W-2:0], fits};
        rem_d = fits ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      end
      bcd_pkg::DIV_DONE: begin
        stat_o.done = 1'b1;
      end
      default: begin
        stat_o.idle = 1'b0;
      end
    endcase
    sum_o  = sum_q;
    quot_o = quo_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bcd_pkg::DIV_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
    sum_q <= sum_d;
  end

endmodule

`default_nettype wire

### hw/rtl/block_change_detector_unit.sv
// ----------------------------------------------------------------------------
// block_change_detector_unit: block based frame difference change detector
// sums over-threshold RGB differences per square block and scores each block
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                   payload
// s_axis    in         s_axis_tvalid/tready        tdata pixel pair, tlast end of block
// m_axis    out        m_axis_tvalid/tready        tdata sum, score, active flag
// cfg       in         cfg_valid_i/cfg_ready_o     cfg_index_i register, cfg_data_i value
//
// non-last pixels are taken one per cycle while the divider is idle, lanes and saturating
// sum settle in that cycle; a last pixel starts the divider: QUOT_W (18) quotient
// bits, one a cycle, then a hand-over, after which the next pixel is taken; a held
// result keeps the divider from handing over and the input closed until it leaves;
// with the divider idle, pixels keep accumulating behind a held result
// reset clears sum, divider and output valid; registers return to 5, 40 and 30
// ----------------------------------------------------------------------------
`default_nettype none

module block_change_detector_unit #(
  parameter int unsigned MAX_HALF_SIDE = 16
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  // first_red, first_green, first_blue, second_red, second_green, second_blue
  input  wire logic [bcd_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  input  wire logic                               s_axis_tlast,   // last_in_block
  input  wire logic                               s_axis_tvalid,
  output logic                                    s_axis_tready,
  // block_sum [19:0], block_score [29:20], block_active [30], zero [31]
  output logic      [bcd_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
  output logic                                    m_axis_tvalid,
  input  wire logic                               m_axis_tready,
  input  wire logic                               cfg_valid_i,
  output logic                                    cfg_ready_o,
  input  wire logic [bcd_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [bcd_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  // configuration registers
  logic [bcd_pkg::HALF_W-1:0] half_q, half_d;
  logic [bcd_pkg::CTHR_W-1:0] cthr_q, cthr_d;
  logic [bcd_pkg::ATHR_W-1:0] athr_q, athr_d;

  logic [bcd_pkg::NUM_CHAN-1:0][bcd_pkg::PIX_W-1:0] first_px, second_px, term;

  logic                        in_acc;
  logic [bcd_pkg::SUM_W-1:0]   sum_next;
  bcd_pkg::div_ctrl_t          div_ctrl;
  bcd_pkg::div_stat_t          div_stat;
  logic [bcd_pkg::SUM_W-1:0]   div_sum;
  logic [bcd_pkg::QUOT_W-1:0]  div_quot;

  // output register
  logic                          out_valid_q, out_valid_d;
  logic [bcd_pkg::SUM_W-1:0]     out_sum_q, out_sum_d;
  logic [bcd_pkg::SCORE_W-1:0]   out_score_q, out_score_d;
  logic                          out_active_q, out_active_d;
  logic                          out_free;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    half_d = half_q;
    cthr_d = cthr_q;
    athr_d = athr_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        bcd_pkg::REG_HALF_SIDE: half_d = cfg_data_i[bcd_pkg::HALF_W-1:0];
        bcd_pkg::REG_CHAN_THR:  cthr_d = cfg_data_i[bcd_pkg::CTHR_W-1:0];
        bcd_pkg::REG_ACT_THR:   athr_d = cfg_data_i[bcd_pkg::ATHR_W-1:0];
        default:                half_d = half_q;  // unknown index, write dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      half_q <= bcd_pkg::HALF_RST;
      cthr_q <= bcd_pkg::CTHR_RST;
      athr_q <= bcd_pkg::ATHR_RST;
    end else begin
      half_q <= half_d;
      cthr_q <= cthr_d;
      athr_q <= athr_d;
    end
  end

  // unpack the pixel pair: first frame channels low, second frame above
  always_comb begin
    for (int c = 0; c < bcd_pkg::NUM_CHAN; c++) begin
      first_px[c]  = s_axis_tdata[c*bcd_pkg::PIX_W +: bcd_pkg::PIX_W];
      second_px[c] = s_axis_tdata[(c+bcd_pkg::NUM_CHAN)*bcd_pkg::PIX_W +: bcd_pkg::PIX_W];
    end
  end

  // one lane per color channel
  for (genvar c = 0; c < bcd_pkg::NUM_CHAN; c++) begin : g_lane
    bcd_lane u_lane (
      .first_i  (first_px[c]),
      .second_i (second_px[c]),
      .thr_i    (cthr_q),
      .term_o   (term[c])
    );
  end

  // input is taken whenever the divider is not busy with a block score
  assign s_axis_tready = div_stat.idle;
  assign in_acc        = s_axis_tvalid && div_stat.idle;

  bcd_merge u_merge (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .term_i   (term),
    .accept_i (in_acc),
    .last_i   (s_axis_tlast),
    .sum_o    (sum_next)
  );

  assign out_free      = !out_valid_q || m_axis_tready;
  assign div_ctrl.start = in_acc && s_axis_tlast;
  assign div_ctrl.take  = div_stat.done && out_free;

  bcd_div #(
    .MAX_HALF_SIDE (MAX_HALF_SIDE)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .sum_i  (sum_next),
    .half_i (half_q),
    .stat_o (div_stat),
    .sum_o  (div_sum),
    .quot_o (div_quot)
  );

  // score saturates; the activity compare uses the full quotient
  always_comb begin
    out_valid_d  = out_valid_q;
    out_sum_d    = out_sum_q;
    out_score_d  = out_score_q;
    out_active_d = out_active_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (div_ctrl.take) begin
      out_valid_d  = 1'b1;
      out_sum_d    = div_sum;
      out_score_d  = (div_quot[bcd_pkg::QUOT_W-1:bcd_pkg::SCORE_W] != '0)
                   ? bcd_pkg::SCORE_MAX : div_quot[bcd_pkg::SCORE_W-1:0];
      out_active_d = div_quot > bcd_pkg::QUOT_W'(athr_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_sum_q    <= out_sum_d;
    out_score_q  <= out_score_d;
    out_active_q <= out_active_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_active_q, out_score_q, out_sum_q};

endmodule

`default_nettype wire

### hw/rtl/bcd_checker.sv
// ----------------------------------------------------------------------------
// bcd_checker: port level checks of the block change detector
// watches the stream and result ports over time, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bcd_checker (
  input wire logic                            clk_i,
  input wire logic                            rst_ni,
  input wire logic                            s_axis_tlast,
  input wire logic                            s_axis_tvalid,
  input wire logic                            s_axis_tready,
  input wire logic [bcd_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  input wire logic                            m_axis_tvalid,
  input wire logic                            m_axis_tready
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // a last item starts the divider, input closes next cycle
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input still open after last item");

  // a new result only comes out of a divider hand-over
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result without divider run");

  // an empty block scores zero and is never active
  a_zero_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tdata[19:0] == 20'd0) |-> (m_axis_tdata[31:20] == 12'd0))
    else $error("nonzero score on zero sum");

endmodule

bind block_change_detector_unit bcd_checker u_bcd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tlast  (s_axis_tlast),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);

`default_nettype wire
